>>> src/chull_pkg.sv
// Shared types and constants for the convex hull block.
package chull_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic               set_end;
   } req_type;

   typedef struct packed {
      logic signed [15:0] hull_x;
      logic signed [15:0] hull_y;
      logic               hull_end;
      logic               overflowed;
   } rsp_type;

   // result of one orientation test
   typedef struct packed {
      logic done;
      logic pos;     // cross(o,a,b) > 0
      logic zero;    // cross(o,a,b) == 0
      logic nearer;  // |a-o|^2 < |b-o|^2
   } geom_res_type;

endpackage

>>> src/chull_geom.sv
// Orientation and distance test on three points with a shared multiplier pair.
module chull_geom import chull_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  point_type    pt_o,
   input  point_type    pt_a,
   input  point_type    pt_b,
   output geom_res_type res
);

   typedef enum logic [2:0] {G_IDLE, G_M1, G_M2, G_M3, G_M4} phase_type;

   phase_type                  phase_ff, phase_in;
   logic signed [DIFF_W-1:0]   ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [DIFF_W-1:0]   ax_in, ay_in, bx_in, by_in;
   logic signed [PROD_W-1:0]   m1_ff, m2_ff, m1_in, m2_in;
   logic signed [CROSS_W-1:0]  cross_ff, cross_in, da_ff, da_in, db;

   always_comb begin
      phase_in = phase_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      m1_in    = m1_ff;
      m2_in    = m2_ff;
      cross_in = cross_ff;
      da_in    = da_ff;
      case (phase_ff)
         G_IDLE: begin
            if (start) begin
               ax_in    = DIFF_W'(pt_a.x) - DIFF_W'(pt_o.x);
               ay_in    = DIFF_W'(pt_a.y) - DIFF_W'(pt_o.y);
               bx_in    = DIFF_W'(pt_b.x) - DIFF_W'(pt_o.x);
               by_in    = DIFF_W'(pt_b.y) - DIFF_W'(pt_o.y);
               phase_in = G_M1;
            end
         end
         G_M1: begin
            m1_in    = ax_ff * by_ff;
            m2_in    = ay_ff * bx_ff;
            phase_in = G_M2;
         end
         G_M2: begin
            cross_in = CROSS_W'(m1_ff) - CROSS_W'(m2_ff);
            m1_in    = ax_ff * ax_ff;
            m2_in    = ay_ff * ay_ff;
            phase_in = G_M3;
         end
         G_M3: begin
            da_in    = CROSS_W'(m1_ff) + CROSS_W'(m2_ff);
            m1_in    = bx_ff * bx_ff;
            m2_in    = by_ff * by_ff;
            phase_in = G_M4;
         end
         G_M4: begin
            phase_in = G_IDLE;
         end
         default: begin
            phase_in = G_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= G_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      bx_ff    <= bx_in;
      by_ff    <= by_in;
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      cross_ff <= cross_in;
      da_ff    <= da_in;
   end

   assign db         = CROSS_W'(m1_ff) + CROSS_W'(m2_ff);
   assign res.done   = (phase_ff == G_M4);
   assign res.pos    = (cross_ff > 0);
   assign res.zero   = (cross_ff == 0);
   assign res.nearer = (da_ff < db);

endmodule

>>> src/convex_hull_2d.sv
// Top level of the Graham-scan convex hull block.
//
// Usage:
//  - req channel: one point per request (point_x, point_y, Q8.8). A request with
//    set_end high closes the set; its point is stored and the hull starts.
//  - rsp channel: one response per hull vertex, counterclockwise from the lowest
//    (then leftmost) point; hull_end marks the last one, overflowed is set on
//    every vertex of a set that lost points beyond MAX_POINTS.
//  - Sets of one or two points come back unchanged, in arrival order.
//  - Loading takes one point per cycle. The hull phase is bound by the point
//    memory (one write port, one registered read port) and the orientation
//    unit; it runs a pivot scan, an insertion sort by angle (n^2/2 compares
//    worst case), a stack scan with orientation tests, and then emits the
//    hull vertices one at a time.
//  - req_ready is high only while loading; no new set is taken during the hull.
//  - The response sits in an output register; if rsp_ready stays low the block
//    simply holds that vertex and waits.
//  - Reset (synchronous) empties the point set and clears the drop flag. The
//    memories are not cleared; only written entries are ever read.
module convex_hull_2d import chull_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [4:0] {
      S_LOAD, S_PRD, S_PCMP, S_SWRD, S_SWA, S_SWB,
      S_IRD, S_IGET, S_IRJ, S_IST, S_ICMP,
      S_CRD, S_CGOT, S_CCMP, S_CSRD, S_CSWT, S_CSP, S_CPUSH,
      S_ESRD, S_EPRD, S_EPWT
   } state_type;

   // point memory and hull stack memory
   point_type          store_mem [MAX_POINTS];
   logic [IDX_W-1:0]   stack_mem [MAX_POINTS];

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               drop_ff, drop_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   d_ff, d_in;
   logic [IDX_W-1:0]   piv_ff, piv_in;
   point_type          best_ff, best_in;
   point_type          p0_ff, p0_in;
   point_type          tmp_ff, tmp_in;
   point_type          top_ff, top_in;
   point_type          sec_ff, sec_in;
   point_type          cur_ff, cur_in;
   logic               hull_ff, hull_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // memory ports
   logic               st_we, st_re, sk_we, sk_re;
   logic [IDX_W-1:0]   st_wa, st_ra, sk_wa, sk_ra;
   point_type          st_wd, st_rd_ff;
   logic [IDX_W-1:0]   sk_wd, sk_rd_ff;

   // orientation unit
   logic               g_start;
   point_type          g_o, g_a, g_b;
   geom_res_type       g_res;

   logic               req_fire;
   logic               slot_free;
   logic [CNT_W-1:0]   total;
   logic               last_out;
   logic               lower;

   chull_geom u_geom (
      .clock (clock),
      .reset (reset),
      .start (g_start),
      .pt_o  (g_o),
      .pt_a  (g_a),
      .pt_b  (g_b),
      .res   (g_res)
   );

   assign req_ready = (state_ff == S_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign total     = hull_ff ? d_ff : count_ff;
   assign last_out  = (i_ff + CNT_W'(1)) == total;
   // lowest y, then lowest x; first found wins
   assign lower     = (st_rd_ff.y < best_ff.y) ||
                      ((st_rd_ff.y == best_ff.y) && (st_rd_ff.x < best_ff.x));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      d_in         = d_ff;
      piv_in       = piv_ff;
      best_in      = best_ff;
      p0_in        = p0_ff;
      tmp_in       = tmp_ff;
      top_in       = top_ff;
      sec_in       = sec_ff;
      cur_in       = cur_ff;
      hull_in      = hull_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      st_we        = 1'b0;
      st_wa        = '0;
      st_wd        = cur_ff;
      st_re        = 1'b0;
      st_ra        = i_ff[IDX_W-1:0];
      sk_we        = 1'b0;
      sk_wa        = d_ff[IDX_W-1:0];
      sk_wd        = i_ff[IDX_W-1:0];
      sk_re        = 1'b0;
      sk_ra        = i_ff[IDX_W-1:0];
      g_start      = 1'b0;
      g_o          = p0_ff;
      g_a          = tmp_ff;
      g_b          = st_rd_ff;

      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (count_ff < CNT_W'(MAX_POINTS)) begin
                  st_we      = 1'b1;
                  st_wa      = count_ff[IDX_W-1:0];
                  st_wd.x    = coord_type'(req_data.point_x);
                  st_wd.y    = coord_type'(req_data.point_y);
                  count_in   = count_ff + CNT_W'(1);
               end else begin
                  drop_in    = 1'b1;
               end
               if (req_data.set_end) begin
                  i_in = '0;
                  if (count_in < CNT_W'(3)) begin
                     hull_in  = 1'b0;
                     state_in = S_ESRD;
                  end else begin
                     state_in = S_PRD;
                  end
               end
            end
         end
         // pivot search
         S_PRD: begin
            st_re    = 1'b1;
            state_in = S_PCMP;
         end
         S_PCMP: begin
            if ((i_ff == '0) || lower) begin
               best_in = st_rd_ff;
               piv_in  = i_ff[IDX_W-1:0];
            end
            i_in = i_ff + CNT_W'(1);
            state_in = (i_ff + CNT_W'(1) == count_ff) ? S_SWRD : S_PRD;
         end
         // swap pivot into slot 0
         S_SWRD: begin
            st_re    = 1'b1;
            st_ra    = '0;
            state_in = S_SWA;
         end
         S_SWA: begin
            st_we    = 1'b1;
            st_wa    = piv_ff;
            st_wd    = st_rd_ff;
            state_in = S_SWB;
         end
         S_SWB: begin
            st_we    = 1'b1;
            st_wa    = '0;
            st_wd    = best_ff;
            p0_in    = best_ff;
            i_in     = CNT_W'(2);
            state_in = S_IRD;
         end
         // insertion sort by angle around the pivot
         S_IRD: begin
            st_re    = 1'b1;
            state_in = S_IGET;
         end
         S_IGET: begin
            tmp_in   = st_rd_ff;
            j_in     = i_ff[IDX_W-1:0];
            state_in = S_IRJ;
         end
         S_IRJ: begin
            if (j_ff > IDX_W'(1)) begin
               st_re    = 1'b1;
               st_ra    = j_ff - IDX_W'(1);
               state_in = S_IST;
            end else begin
               st_we = 1'b1;
               st_wa = j_ff;
               st_wd = tmp_ff;
               i_in  = i_ff + CNT_W'(1);
               state_in = (i_ff + CNT_W'(1) == count_ff) ? S_CRD : S_IRD;
               if (i_ff + CNT_W'(1) == count_ff) begin
                  i_in = '0;
                  d_in = '0;
               end
            end
         end
         S_IST: begin
            g_start  = 1'b1;
            state_in = S_ICMP;
         end
         S_ICMP: begin
            if (g_res.done) begin
               st_we = 1'b1;
               st_wa = j_ff;
               if (g_res.pos || (g_res.zero && g_res.nearer)) begin
                  st_wd    = st_rd_ff;
                  j_in     = j_ff - IDX_W'(1);
                  state_in = S_IRJ;
               end else begin
                  st_wd = tmp_ff;
                  i_in  = i_ff + CNT_W'(1);
                  state_in = (i_ff + CNT_W'(1) == count_ff) ? S_CRD : S_IRD;
                  if (i_ff + CNT_W'(1) == count_ff) begin
                     i_in = '0;
                     d_in = '0;
                  end
               end
            end
         end
         // stack scan
         S_CRD: begin
            st_re    = 1'b1;
            state_in = S_CGOT;
         end
         S_CGOT: begin
            cur_in = st_rd_ff;
            if (d_ff >= CNT_W'(2)) begin
               g_start  = 1'b1;
               g_o      = sec_ff;
               g_a      = top_ff;
               g_b      = st_rd_ff;
               state_in = S_CCMP;
            end else begin
               state_in = S_CPUSH;
            end
         end
         S_CCMP: begin
            if (g_res.done) begin
               if (!g_res.pos) begin
                  d_in   = d_ff - CNT_W'(1);
                  top_in = sec_ff;
                  state_in = (d_ff - CNT_W'(1) >= CNT_W'(2)) ? S_CSRD : S_CPUSH;
               end else begin
                  state_in = S_CPUSH;
               end
            end
         end
         S_CSRD: begin
            sk_re    = 1'b1;
            sk_ra    = IDX_W'(d_ff - CNT_W'(2));
            state_in = S_CSWT;
         end
         S_CSWT: begin
            st_re    = 1'b1;
            st_ra    = sk_rd_ff;
            state_in = S_CSP;
         end
         S_CSP: begin
            sec_in   = st_rd_ff;
            g_start  = 1'b1;
            g_o      = st_rd_ff;
            g_a      = top_ff;
            g_b      = cur_ff;
            state_in = S_CCMP;
         end
         S_CPUSH: begin
            sk_we  = 1'b1;
            sec_in = top_ff;
            top_in = cur_ff;
            d_in   = d_ff + CNT_W'(1);
            i_in   = i_ff + CNT_W'(1);
            if (i_ff + CNT_W'(1) == count_ff) begin
               i_in     = '0;
               hull_in  = 1'b1;
               state_in = S_ESRD;
            end else begin
               state_in = S_CRD;
            end
         end
         // emit vertices
         S_ESRD: begin
            sk_re    = hull_ff;
            state_in = S_EPRD;
         end
         S_EPRD: begin
            st_re    = 1'b1;
            st_ra    = hull_ff ? sk_rd_ff : i_ff[IDX_W-1:0];
            state_in = S_EPWT;
         end
         S_EPWT: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.hull_x      = 16'(st_rd_ff.x);
               rsp_in.hull_y      = 16'(st_rd_ff.y);
               rsp_in.hull_end    = last_out;
               rsp_in.overflowed  = drop_ff;
               i_in               = i_ff + CNT_W'(1);
               if (last_out) begin
                  count_in = '0;
                  d_in     = '0;
                  drop_in  = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_ESRD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         d_ff         <= '0;
         hull_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         d_ff         <= d_in;
         hull_ff      <= hull_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      piv_ff  <= piv_in;
      best_ff <= best_in;
      p0_ff   <= p0_in;
      tmp_ff  <= tmp_in;
      top_ff  <= top_in;
      sec_ff  <= sec_in;
      cur_ff  <= cur_in;
      rsp_ff  <= rsp_in;
   end

   // point memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_wa] <= st_wd;
      end
      if (st_re) begin
         st_rd_ff <= store_mem[st_ra];
      end
   end

   // hull stack memory
   always_ff @(posedge clock) begin
      if (sk_we) begin
         stack_mem[sk_wa] <= sk_wd;
      end
      if (sk_re) begin
         sk_rd_ff <= stack_mem[sk_ra];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // point count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above capacity");

   // stack never deeper than the point set
   a_depth_cap: assert property (@(posedge clock) disable iff (reset)
      d_ff <= count_ff)
      else $error("hull stack deeper than point set");

   // orientation results only land while a compare is awaited
   a_geom_done: assert property (@(posedge clock) disable iff (reset)
      g_res.done |-> (state_ff == S_ICMP || state_ff == S_CCMP))
      else $error("orientation result outside compare state");

   // a new response is only loaded when the previous one has left
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending response overwritten");

endmodule
